// ===== hw/rtl/sdldc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sun disk compositor package
// Shared constants, register codes, angle table and sideband types.
// ----------------------------------------------------------------------------
package sdldc_pkg;

  // Default parameter values
  localparam int unsigned AFB_DEF          = 24;
  localparam int unsigned CORDIC_STEPS_DEF = 24;

  // Fixed arithmetic constants
  localparam int unsigned CORDIC_PRESHIFT = 24;
  localparam int unsigned CORDIC_ZW       = 36;   // signed angle accumulator
  localparam int unsigned RHO_BITS        = 30;   // rho quotient bits
  localparam logic [33:0] PI_Q32          = 34'd13493037705;
  localparam logic [30:0] ONE_Q30         = 31'h4000_0000;

  // Register reset values
  localparam logic [15:0] SUN_DIR_X_RST   = 16'd0;
  localparam logic [15:0] SUN_DIR_Y_RST   = 16'd16384;
  localparam logic [15:0] SUN_DIR_Z_RST   = 16'd0;
  localparam logic [47:0] SUN_COLOR_RST   = 48'h1000_1000_1000;
  localparam logic [31:0] SUN_INTENS_RST  = 32'h0001_0000;
  localparam logic [15:0] LIMB_U_RST      = 16'd39322;
  localparam logic [23:0] ANG_RADIUS_RST  = 24'd77597;

  // Register indexes
  typedef enum logic [2:0] {
    CFG_SUN_DIR_X      = 3'd0,
    CFG_SUN_DIR_Y      = 3'd1,
    CFG_SUN_DIR_Z      = 3'd2,
    CFG_SUN_COLOR_RGB  = 3'd3,
    CFG_SUN_INTENSITY  = 3'd4,
    CFG_LIMB_U         = 3'd5,
    CFG_ANGULAR_RADIUS = 3'd6
  } cfg_idx_e;

  // atan(2^-i) in Q32 for the first steps
  localparam logic [31:0] ATAN_Q32 [11] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303
  };

  // Rotation angle of CORDIC step i, Q32
  function automatic logic [31:0] step_angle(input int unsigned i);
    logic [63:0] pw;
    pw = 64'd1 << (32 - i);
    if (i < 11) return ATAN_Q32[i];
    return pw[31:0];
  endfunction

  // Sideband that travels beside the angle datapath
  typedef struct packed {
    logic        zero_view;
    logic        dot_neg;
    logic [31:0] sky_r;
    logic [31:0] sky_g;
    logic [31:0] sky_b;
  } pix_side_t;

  typedef struct packed {
    logic [31:0] xmag;
    pix_side_t   pix;
  } root_side_t;

  // Sideband for the darkening datapath
  typedef struct packed {
    logic        hit;
    logic [31:0] sky_r;
    logic [31:0] sky_g;
    logic [31:0] sky_b;
  } fin_side_t;

  typedef struct packed {
    logic        in_disk;
    logic [31:0] out_r;
    logic [31:0] out_g;
    logic [31:0] out_b;
  } res_t;

endpackage

// ===== hw/rtl/sdldc_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Floor square root, one result bit per stage, sideband carried alongside.
// ----------------------------------------------------------------------------
module sdldc_isqrt #(
  parameter int unsigned IN_W   = 64,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [IN_W-1:0]     rad_i,
  input  logic [SIDE_W-1:0]   side_i,
  output logic                valid_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [SIDE_W-1:0]   side_o
);

  localparam int unsigned STEPS = IN_W / 2;

  logic [IN_W-1:0]   n_q    [STEPS];
  logic [IN_W-1:0]   r_q    [STEPS];
  logic [SIDE_W-1:0] side_q [STEPS];
  logic [STEPS-1:0]  v_q;

  // Valid shift line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STEPS-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    localparam logic [IN_W:0] BIT = (IN_W + 1)'(1) << (IN_W - 2 - 2 * k);

    logic [IN_W-1:0]   n_in, r_in, n_d, r_d;
    logic [SIDE_W-1:0] s_in;
    logic [IN_W:0]     trial;

    if (k == 0) begin : g_first
      assign n_in = rad_i;
      assign r_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign n_in = n_q[k-1];
      assign r_in = r_q[k-1];
      assign s_in = side_q[k-1];
    end

    // One restoring digit
    always_comb begin
      trial = {1'b0, r_in} + BIT;
      if ({1'b0, n_in} >= trial) begin
        n_d = n_in - trial[IN_W-1:0];
        r_d = (r_in >> 1) + BIT[IN_W-1:0];
      end else begin
        n_d = n_in;
        r_d = r_in >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= n_d;
        r_q[k]    <= r_d;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign root_o  = r_q[STEPS-1][IN_W/2-1:0];
  assign side_o  = side_q[STEPS-1];

endmodule

// ===== hw/rtl/sdldc_cordic.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Pipelined vectoring CORDIC
// atan2(y, x) for non-negative magnitudes, one rotation per stage, Q32 angle.
// ----------------------------------------------------------------------------
module sdldc_cordic
  import sdldc_pkg::*;
#(
  parameter int unsigned STEPS  = CORDIC_STEPS_DEF,
  parameter int unsigned SIDE_W = 1
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  logic [31:0]                 ymag_i,
  input  logic [31:0]                 xmag_i,
  input  logic [SIDE_W-1:0]           side_i,
  output logic                        valid_o,
  output logic signed [CORDIC_ZW-1:0] z_o,
  output logic [SIDE_W-1:0]           side_o
);

  // Magnitude after preshift plus CORDIC gain headroom
  localparam int unsigned XW = 32 + CORDIC_PRESHIFT + 3;

  logic signed [XW-1:0]        x_q    [STEPS];
  logic signed [XW-1:0]        y_q    [STEPS];
  logic signed [CORDIC_ZW-1:0] z_q    [STEPS];
  logic [SIDE_W-1:0]           side_q [STEPS];
  logic [STEPS-1:0]            v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[STEPS-2:0], valid_i};
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    localparam logic signed [CORDIC_ZW-1:0] ANG = signed'(CORDIC_ZW'(step_angle(k)));

    logic signed [XW-1:0]        x_in, y_in, x_d, y_d, dx, dy, nx, ny;
    logic signed [CORDIC_ZW-1:0] z_in, z_d;
    logic [SIDE_W-1:0]           s_in;

    if (k == 0) begin : g_first
      assign x_in = signed'(XW'(xmag_i) << CORDIC_PRESHIFT);
      assign y_in = signed'(XW'(ymag_i) << CORDIC_PRESHIFT);
      assign z_in = '0;
      assign s_in = side_i;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign y_in = y_q[k-1];
      assign z_in = z_q[k-1];
      assign s_in = side_q[k-1];
    end

    // Shifts truncate toward zero
    always_comb begin
      nx = -x_in;
      ny = -y_in;
      dx = y_in[XW-1] ? -(ny >>> k) : (y_in >>> k);
      dy = x_in[XW-1] ? -(nx >>> k) : (x_in >>> k);
      if (!y_in[XW-1] && (y_in != '0)) begin
        x_d = x_in + dx;
        y_d = y_in - dy;
        z_d = z_in + ANG;
      end else begin
        x_d = x_in - dx;
        y_d = y_in + dy;
        z_d = z_in - ANG;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[k]    <= x_d;
        y_q[k]    <= y_d;
        z_q[k]    <= z_d;
        side_q[k] <= s_in;
      end
    end
  end

  assign valid_o = v_q[STEPS-1];
  assign z_o     = z_q[STEPS-1];
  assign side_o  = side_q[STEPS-1];

endmodule

// ===== hw/rtl/sun_disk_limb_darkened_composite_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sun disk compositor with linear limb darkening
// Adds a limb-darkened sun disk to a stream of sky pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one pixel per item: view direction and sky RGB radiance.
//   m_axis returns one item per pixel, composited RGB in tdata and the
//   in-disk flag in tuser, in input order.
//   The cfg port writes the sun direction, colour, intensity, darkening
//   coefficient and angular radius; write only while no pixel is in flight.
// Timing:
//   One pixel per cycle sustained while the output is not stalled. The
//   delay from acceptance to tvalid comes mostly from the two bit-serial
//   square roots (32 and 31 stages), the CORDIC (one stage per rotation)
//   and the 30-stage rho divider.
// Reset:
//   Clears all valid bits and loads the register defaults (sun straight up
//   the y axis, white colour, unit intensity, u near 0.6).
// Backpressure:
//   The pipeline advances as one; an output register plus a skid entry let
//   the pipe run on after tready drops until a result meets a full output
//   register; s_axis_tready then falls. Nothing is lost or repeated.
// ----------------------------------------------------------------------------
module sun_disk_limb_darkened_composite_top
  import sdldc_pkg::*;
#(
  parameter int unsigned ANGLE_FRAC_BITS = AFB_DEF,
  parameter int unsigned CORDIC_STEPS    = CORDIC_STEPS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Pixel input
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [143:0] s_axis_tdata,  // view_x, view_y, view_z, sky_r, sky_g, sky_b
  // Pixel output
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [95:0]  m_axis_tdata,  // out_r, out_g, out_b
  output logic         m_axis_tuser,  // in_disk
  // Register writes
  input  logic         cfg_we_i,
  input  logic [2:0]   cfg_idx_i,
  input  logic [47:0]  cfg_data_i
);

  localparam int unsigned AFB = ANGLE_FRAC_BITS;
  localparam int unsigned TW  = AFB + 3;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic signed [15:0] sun_x_q, sun_y_q, sun_z_q;
  logic [47:0]        color_q;
  logic [31:0]        intens_q;
  logic [15:0]        limb_u_q;
  logic [23:0]        radius_cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sun_x_q      <= SUN_DIR_X_RST;
      sun_y_q      <= SUN_DIR_Y_RST;
      sun_z_q      <= SUN_DIR_Z_RST;
      color_q      <= SUN_COLOR_RST;
      intens_q     <= SUN_INTENS_RST;
      limb_u_q     <= LIMB_U_RST;
      radius_cfg_q <= ANG_RADIUS_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SUN_DIR_X:      sun_x_q      <= cfg_data_i[15:0];
        CFG_SUN_DIR_Y:      sun_y_q      <= cfg_data_i[15:0];
        CFG_SUN_DIR_Z:      sun_z_q      <= cfg_data_i[15:0];
        CFG_SUN_COLOR_RGB:  color_q      <= cfg_data_i;
        CFG_SUN_INTENSITY:  intens_q     <= cfg_data_i[31:0];
        CFG_LIMB_U:         limb_u_q     <= cfg_data_i[15:0];
        CFG_ANGULAR_RADIUS: radius_cfg_q <= cfg_data_i[23:0];
        default: ;
      endcase
    end
  end

  // Radius at the angle precision
  logic [AFB-1:0] radius;
  if (AFB >= 24) begin : g_rad_up
    assign radius = AFB'(radius_cfg_q) << (AFB - 24);
  end else begin : g_rad_dn
    assign radius = AFB'(radius_cfg_q >> (24 - AFB));
  end

  logic sun_nz;
  assign sun_nz = (sun_x_q != '0) || (sun_y_q != '0) || (sun_z_q != '0);

  // Colour times intensity, per channel, refreshed from the registers
  logic [47:0] ci_q [3];
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 3; c++) begin
      ci_q[c] <= 48'(color_q[16*c +: 16]) * 48'(intens_q);
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: whole pipe moves while the skid entry is free
  // --------------------------------------------------------------------------
  logic en;
  logic spare_v_q;
  assign en            = !spare_v_q;
  assign s_axis_tready = en;

  // --------------------------------------------------------------------------
  // Stage A: cross and dot partial products
  // --------------------------------------------------------------------------
  logic signed [15:0] vx, vy, vz;
  assign vx = s_axis_tdata[15:0];
  assign vy = s_axis_tdata[31:16];
  assign vz = s_axis_tdata[47:32];

  logic               a_v_q;
  logic signed [31:0] a_yz_q, a_zy_q, a_zx_q, a_xz_q, a_xy_q, a_yx_q;
  logic signed [31:0] a_xx_q, a_yy_q, a_zz_q;
  pix_side_t          a_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_yz_q             <= 32'(vy) * 32'(sun_z_q);
      a_zy_q             <= 32'(vz) * 32'(sun_y_q);
      a_zx_q             <= 32'(vz) * 32'(sun_x_q);
      a_xz_q             <= 32'(vx) * 32'(sun_z_q);
      a_xy_q             <= 32'(vx) * 32'(sun_y_q);
      a_yx_q             <= 32'(vy) * 32'(sun_x_q);
      a_xx_q             <= 32'(vx) * 32'(sun_x_q);
      a_yy_q             <= 32'(vy) * 32'(sun_y_q);
      a_zz_q             <= 32'(vz) * 32'(sun_z_q);
      a_side_q.zero_view <= (vx == '0) && (vy == '0) && (vz == '0);
      a_side_q.dot_neg   <= 1'b0;
      a_side_q.sky_r     <= s_axis_tdata[79:48];
      a_side_q.sky_g     <= s_axis_tdata[111:80];
      a_side_q.sky_b     <= s_axis_tdata[143:112];
    end
  end

  // --------------------------------------------------------------------------
  // Stage B: cross components and dot product
  // --------------------------------------------------------------------------
  logic               b_v_q;
  logic signed [32:0] b_cx_q, b_cy_q, b_cz_q;
  logic signed [33:0] b_dot_q;
  pix_side_t          b_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_cx_q   <= 33'(a_yz_q) - 33'(a_zy_q);
      b_cy_q   <= 33'(a_zx_q) - 33'(a_xz_q);
      b_cz_q   <= 33'(a_xy_q) - 33'(a_yx_q);
      b_dot_q  <= 34'(a_xx_q) + 34'(a_yy_q) + 34'(a_zz_q);
      b_side_q <= a_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage C: magnitudes and squares
  // --------------------------------------------------------------------------
  logic               c_v_q;
  logic [63:0]        c_sx_q, c_sy_q, c_sz_q;
  root_side_t         c_side_q;
  logic [31:0]        cx_abs, cy_abs, cz_abs;
  logic signed [32:0] cx_neg, cy_neg, cz_neg;
  logic signed [33:0] dot_neg_val;

  always_comb begin
    cx_neg      = -b_cx_q;
    cy_neg      = -b_cy_q;
    cz_neg      = -b_cz_q;
    dot_neg_val = -b_dot_q;
    cx_abs      = b_cx_q[32] ? cx_neg[31:0] : b_cx_q[31:0];
    cy_abs      = b_cy_q[32] ? cy_neg[31:0] : b_cy_q[31:0];
    cz_abs      = b_cz_q[32] ? cz_neg[31:0] : b_cz_q[31:0];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      c_sx_q                 <= 64'(cx_abs) * 64'(cx_abs);
      c_sy_q                 <= 64'(cy_abs) * 64'(cy_abs);
      c_sz_q                 <= 64'(cz_abs) * 64'(cz_abs);
      c_side_q.xmag          <= b_dot_q[33] ? dot_neg_val[31:0] : b_dot_q[31:0];
      c_side_q.pix.zero_view <= b_side_q.zero_view;
      c_side_q.pix.dot_neg   <= b_dot_q[33];
      c_side_q.pix.sky_r     <= b_side_q.sky_r;
      c_side_q.pix.sky_g     <= b_side_q.sky_g;
      c_side_q.pix.sky_b     <= b_side_q.sky_b;
    end
  end

  // --------------------------------------------------------------------------
  // Stage D: squared cross length
  // --------------------------------------------------------------------------
  logic       d_v_q;
  logic [63:0] d_sum_q;
  root_side_t d_side_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      d_sum_q  <= c_sx_q + c_sy_q + c_sz_q;
      d_side_q <= c_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Cross length, then angle
  // --------------------------------------------------------------------------
  logic        r1_v;
  logic [31:0] r1_root;
  root_side_t  r1_side;

  sdldc_isqrt #(
    .IN_W   (64),
    .SIDE_W ($bits(root_side_t))
  ) u_cross_len (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (d_v_q),
    .rad_i   (d_sum_q),
    .side_i  (d_side_q),
    .valid_o (r1_v),
    .root_o  (r1_root),
    .side_o  (r1_side)
  );

  logic                        cd_v;
  logic signed [CORDIC_ZW-1:0] cd_z;
  pix_side_t                   cd_side;

  sdldc_cordic #(
    .STEPS  (CORDIC_STEPS),
    .SIDE_W ($bits(pix_side_t))
  ) u_angle (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (r1_v),
    .ymag_i  (r1_root),
    .xmag_i  (r1_side.xmag),
    .side_i  (r1_side.pix),
    .valid_o (cd_v),
    .z_o     (cd_z),
    .side_o  (cd_side)
  );

  // --------------------------------------------------------------------------
  // Stage E: fold angle, round, disk test
  // --------------------------------------------------------------------------
  logic      e_v_q;
  logic [TW-1:0] e_theta_q;
  fin_side_t e_side_q;
  logic [33:0] th_raw, th32;
  logic [34:0] th_sum;
  logic [TW-1:0] theta;

  always_comb begin
    th_raw = cd_z[CORDIC_ZW-1] ? '0 : cd_z[33:0];
    if (cd_side.dot_neg) begin
      th32 = (th_raw >= PI_Q32) ? '0 : PI_Q32 - th_raw;
    end else begin
      th32 = th_raw;
    end
    th_sum = 35'(th32) + (35'(1) << (31 - AFB));
    theta  = th_sum[34:32-AFB];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e_theta_q      <= theta;
      e_side_q.hit   <= !cd_side.zero_view && sun_nz && (radius != '0) &&
                        (theta < TW'(radius));
      e_side_q.sky_r <= cd_side.sky_r;
      e_side_q.sky_g <= cd_side.sky_g;
      e_side_q.sky_b <= cd_side.sky_b;
    end
  end

  // --------------------------------------------------------------------------
  // rho = theta / R in Q0.30, one quotient bit per stage
  // --------------------------------------------------------------------------
  logic [AFB-1:0]      dv_rem_q  [RHO_BITS];
  logic [RHO_BITS-1:0] dv_quo_q  [RHO_BITS];
  fin_side_t           dv_side_q [RHO_BITS];
  logic [RHO_BITS-1:0] dv_v_q;

  for (genvar k = 0; k < RHO_BITS; k++) begin : g_div
    logic [AFB-1:0]      rem_in, rem_d;
    logic [RHO_BITS-1:0] quo_in;
    fin_side_t           s_in;
    logic [AFB:0]        r2;
    logic                qb;

    if (k == 0) begin : g_first
      assign rem_in = e_theta_q[AFB-1:0];
      assign quo_in = '0;
      assign s_in   = e_side_q;
    end else begin : g_next
      assign rem_in = dv_rem_q[k-1];
      assign quo_in = dv_quo_q[k-1];
      assign s_in   = dv_side_q[k-1];
    end

    always_comb begin
      r2 = {rem_in, 1'b0};
      qb = (r2 >= {1'b0, radius});
      rem_d = qb ? AFB'(r2 - {1'b0, radius}) : r2[AFB-1:0];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dv_rem_q[k]  <= rem_d;
        dv_quo_q[k]  <= {quo_in[RHO_BITS-2:0], qb};
        dv_side_q[k] <= s_in;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage F: rho squared; stage G: square root argument
  // --------------------------------------------------------------------------
  logic        f_v_q, g_v_q;
  logic [59:0] rho_sq;
  logic [29:0] f_rho2_q;
  fin_side_t   f_side_q, g_side_q;
  logic [61:0] g_arg_q;
  logic [30:0] one_m_rho2;

  assign rho_sq     = 60'(dv_quo_q[RHO_BITS-1]) * 60'(dv_quo_q[RHO_BITS-1]);
  assign one_m_rho2 = ONE_Q30 - 31'(f_rho2_q);

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_rho2_q <= rho_sq[59:30];
      f_side_q <= dv_side_q[RHO_BITS-1];
      g_arg_q  <= {1'b0, one_m_rho2, 30'd0};
      g_side_q <= f_side_q;
    end
  end

  logic        r2_v;
  logic [30:0] r2_root;
  fin_side_t   r2_side;

  sdldc_isqrt #(
    .IN_W   (62),
    .SIDE_W ($bits(fin_side_t))
  ) u_mu (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (g_v_q),
    .rad_i   (g_arg_q),
    .side_i  (g_side_q),
    .valid_o (r2_v),
    .root_o  (r2_root),
    .side_o  (r2_side)
  );

  // --------------------------------------------------------------------------
  // Stage H: u * (1 - mu); stage I: factor rounded to Q16
  // --------------------------------------------------------------------------
  logic        h_v_q, i_v_q, j_v_q;
  logic [46:0] h_prod_q;
  fin_side_t   h_side_q, i_side_q, j_side_q;
  logic [16:0] i_f16_q;
  logic [30:0] f_full;
  logic [31:0] f_rnd;

  always_comb begin
    f_full = ONE_Q30 - h_prod_q[46:16];
    f_rnd  = 32'(f_full) + 32'd8192;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      h_prod_q <= 47'(limb_u_q) * 47'(ONE_Q30 - r2_root);
      h_side_q <= r2_side;
      i_f16_q  <= f_rnd[30:14];
      i_side_q <= h_side_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage J: sun term per channel
  // --------------------------------------------------------------------------
  logic [64:0] j_term_q [3];

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int c = 0; c < 3; c++) begin
        j_term_q[c] <= 65'(ci_q[c]) * 65'(i_f16_q);
      end
      j_side_q <= i_side_q;
    end
  end

  // Final add with saturation
  res_t        fin;
  logic [37:0] sum_r, sum_g, sum_b;

  always_comb begin
    sum_r = 38'(j_side_q.sky_r) + 38'(j_term_q[0][64:28]);
    sum_g = 38'(j_side_q.sky_g) + 38'(j_term_q[1][64:28]);
    sum_b = 38'(j_side_q.sky_b) + 38'(j_term_q[2][64:28]);
    fin.in_disk = j_side_q.hit;
    if (j_side_q.hit) begin
      fin.out_r = (sum_r[37:32] != '0) ? '1 : sum_r[31:0];
      fin.out_g = (sum_g[37:32] != '0) ? '1 : sum_g[31:0];
      fin.out_b = (sum_b[37:32] != '0) ? '1 : sum_b[31:0];
    end else begin
      fin.out_r = j_side_q.sky_r;
      fin.out_g = j_side_q.sky_g;
      fin.out_b = j_side_q.sky_b;
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits of the stages in this module
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q  <= 1'b0;
      b_v_q  <= 1'b0;
      c_v_q  <= 1'b0;
      d_v_q  <= 1'b0;
      e_v_q  <= 1'b0;
      dv_v_q <= '0;
      f_v_q  <= 1'b0;
      g_v_q  <= 1'b0;
      h_v_q  <= 1'b0;
      i_v_q  <= 1'b0;
      j_v_q  <= 1'b0;
    end else if (en) begin
      a_v_q  <= s_axis_tvalid;
      b_v_q  <= a_v_q;
      c_v_q  <= b_v_q;
      d_v_q  <= c_v_q;
      e_v_q  <= cd_v;
      dv_v_q <= {dv_v_q[RHO_BITS-2:0], e_v_q};
      f_v_q  <= dv_v_q[RHO_BITS-1];
      g_v_q  <= f_v_q;
      h_v_q  <= r2_v;
      i_v_q  <= h_v_q;
      j_v_q  <= i_v_q;
    end
  end

  // --------------------------------------------------------------------------
  // Output register and skid entry
  // --------------------------------------------------------------------------
  logic out_v_q;
  res_t out_q, spare_q;
  logic push, pop;

  assign push = en && j_v_q;
  assign pop  = out_v_q && m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q   <= 1'b0;
      spare_v_q <= 1'b0;
    end else if (spare_v_q) begin
      if (pop) begin
        spare_v_q <= 1'b0;
      end
    end else if (push && out_v_q && !pop) begin
      spare_v_q <= 1'b1;
    end else if (push) begin
      out_v_q <= 1'b1;
    end else if (pop) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (spare_v_q) begin
      if (pop) out_q <= spare_q;
    end else if (push && out_v_q && !pop) begin
      spare_q <= fin;
    end else if (push) begin
      out_q <= fin;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {out_q.out_b, out_q.out_g, out_q.out_r};
  assign m_axis_tuser  = out_q.in_disk;

endmodule

// ===== tb/tb_sun_disk_limb_darkened_composite_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sun disk compositor testbench
// Drives pixel items through the compositor and checks every result against
// a bit-accurate predictor of the angle, limb darkening and saturating add.
// It covers directed corner pixels, several register settings and random
// traffic with sender gaps, receiver stalls and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_sun_disk_limb_darkened_composite_top;
  import sdldc_pkg::*;

  localparam logic [2:0] CFG_UNUSED  = 3'd7;  // index past the register file
  localparam int         WDOG_LIMIT  = 20000;
  localparam int         DRAIN_WAIT  = 200;
  localparam logic [63:0] ONE30      = 64'd1 << 30;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;  // view_x, view_y, view_z, sky_r, sky_g, sky_b
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;  // out_r, out_g, out_b
  logic         m_axis_tuser;  // in_disk
  logic         cfg_we_i;
  logic [2:0]   cfg_idx_i;
  logic [47:0]  cfg_data_i;

  sun_disk_limb_darkened_composite_top dut (.*);

  // Register shadow
  logic signed [15:0] sh_dir_x, sh_dir_y, sh_dir_z;
  logic [47:0]        sh_color;
  logic [31:0]        sh_intens;
  logic [15:0]        sh_u;
  logic [23:0]        sh_radius;

  res_t pixel_q[$];
  int   n_fail, n_checked, n_hits, n_sent;
  int   send_idle_pct, recv_stall_pct, hold_len, wdog;

  // Clock
  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  // Bit-serial floor square root
  function automatic logic [63:0] floor_sqrt(logic [63:0] n);
    logic [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Arithmetic shift that truncates toward zero
  function automatic longint shr_trunc(longint v, int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  // Vectoring CORDIC, angle in Q32, clamped at zero
  function automatic logic [63:0] vector_angle(logic [63:0] ym, logic [63:0] xm);
    longint x, y, z, dx, dy, a;
    x = longint'(xm << CORDIC_PRESHIFT);
    y = longint'(ym << CORDIC_PRESHIFT);
    z = 0;
    for (int i = 0; i < CORDIC_STEPS_DEF; i++) begin
      dx = shr_trunc(y, i);
      dy = shr_trunc(x, i);
      a  = (i < 11) ? longint'(ATAN_Q32[i]) : (longint'(1) << (32 - i));
      if (y > 0) begin
        x = x + dx; y = y - dy; z = z + a;
      end else begin
        x = x - dx; y = y + dy; z = z - a;
      end
    end
    return (z < 0) ? 64'd0 : 64'(z);
  endfunction

  // Composited pixel for one view direction and sky
  function automatic res_t composite_pixel(logic [143:0] d);
    res_t        r;
    longint      vx, vy, vz, sx, sy, sz, cx, cy, cz, dot;
    logic [63:0] sky [3];
    logic [63:0] th32, th, rho, rho2, mu, f, f16, col, t, sum, xm;
    vx = longint'($signed(d[15:0]));
    vy = longint'($signed(d[31:16]));
    vz = longint'($signed(d[47:32]));
    sx = longint'(sh_dir_x);
    sy = longint'(sh_dir_y);
    sz = longint'(sh_dir_z);
    sky[0] = {32'd0, d[79:48]};
    sky[1] = {32'd0, d[111:80]};
    sky[2] = {32'd0, d[143:112]};
    r.out_r = d[79:48];
    r.out_g = d[111:80];
    r.out_b = d[143:112];
    r.in_disk = 1'b0;
    if ((vx == 0 && vy == 0 && vz == 0) || (sx == 0 && sy == 0 && sz == 0) ||
        sh_radius == 0)
      return r;
    cx  = vy * sz - vz * sy;
    cy  = vz * sx - vx * sz;
    cz  = vx * sy - vy * sx;
    dot = vx * sx + vy * sy + vz * sz;
    xm  = (dot < 0) ? 64'(-dot) : 64'(dot);
    th32 = vector_angle(floor_sqrt(64'(cx * cx) + 64'(cy * cy) + 64'(cz * cz)), xm);
    if (dot < 0) th32 = (th32 >= PI_Q32) ? 64'd0 : PI_Q32 - th32;
    th = (th32 + (64'd1 << (31 - AFB_DEF))) >> (32 - AFB_DEF);
    if (th >= sh_radius) return r;
    rho  = (th << 30) / sh_radius;
    rho2 = (rho * rho) >> 30;
    mu   = floor_sqrt((ONE30 - rho2) << 30);
    if (mu > ONE30) mu = ONE30;
    f   = ONE30 - ((64'(sh_u) * (ONE30 - mu)) >> 16);
    f16 = (f + (64'd1 << 13)) >> 14;
    for (int k = 0; k < 3; k++) begin
      col = 64'((sh_color >> (16 * k)) & 48'hFFFF);
      t   = col * 64'(sh_intens);
      t   = t * f16;  // largest product is below 2^64, so it never wraps
      sum = sky[k] + (t >> 28);
      sky[k] = (sum > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : sum;
    end
    r.out_r = sky[0][31:0];
    r.out_g = sky[1][31:0];
    r.out_b = sky[2][31:0];
    r.in_disk = 1'b1;
    return r;
  endfunction

  // Receiver: random stalls plus an optional long hold-off
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_len > 0) begin
      hold_len = hold_len - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    res_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pixel_q.size() == 0) begin
        $error("unexpected result item out=%h in_disk=%b", m_axis_tdata, m_axis_tuser);
        n_fail++;
      end else begin
        e = pixel_q.pop_front();
        n_checked++;
        if (e.in_disk) n_hits++;
        if (m_axis_tdata[31:0] !== e.out_r) begin
          $error("out_r expected %h actual %h", e.out_r, m_axis_tdata[31:0]); n_fail++;
        end
        if (m_axis_tdata[63:32] !== e.out_g) begin
          $error("out_g expected %h actual %h", e.out_g, m_axis_tdata[63:32]); n_fail++;
        end
        if (m_axis_tdata[95:64] !== e.out_b) begin
          $error("out_b expected %h actual %h", e.out_b, m_axis_tdata[95:64]); n_fail++;
        end
        if (m_axis_tuser !== e.in_disk) begin
          $error("in_disk expected %b actual %b", e.in_disk, m_axis_tuser); n_fail++;
        end
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      wdog <= 0;
    end else if (wdog >= WDOG_LIMIT) begin
      $display("sun_disk_limb_darkened_composite_top regression: fail");
      $finish;
    end else begin
      wdog <= wdog + 1;
    end
  end

  // One register write, shadow updated alongside
  task automatic write_reg(logic [2:0] idx, logic [47:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    case (idx)
      CFG_SUN_DIR_X:      sh_dir_x  = val[15:0];
      CFG_SUN_DIR_Y:      sh_dir_y  = val[15:0];
      CFG_SUN_DIR_Z:      sh_dir_z  = val[15:0];
      CFG_SUN_COLOR_RGB:  sh_color  = val;
      CFG_SUN_INTENSITY:  sh_intens = val[31:0];
      CFG_LIMB_U:         sh_u      = val[15:0];
      CFG_ANGULAR_RADIUS: sh_radius = val[23:0];
      default: ;
    endcase
  endtask

  task automatic write_all(logic [15:0] x, logic [15:0] y, logic [15:0] z, logic [47:0] c,
                           logic [31:0] in, logic [15:0] u, logic [23:0] rad);
    write_reg(CFG_SUN_DIR_X, {32'd0, x});
    write_reg(CFG_SUN_DIR_Y, {32'd0, y});
    write_reg(CFG_SUN_DIR_Z, {32'd0, z});
    write_reg(CFG_SUN_COLOR_RGB, c);
    write_reg(CFG_SUN_INTENSITY, {16'd0, in});
    write_reg(CFG_LIMB_U, {32'd0, u});
    write_reg(CFG_ANGULAR_RADIUS, {24'd0, rad});
  endtask

  // Send one pixel item, then maybe leave a gap
  task automatic send_pixel(logic [47:0] view, logic [95:0] sky);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sky, view};
    do @(posedge clk_i); while (!s_axis_tready);
    pixel_q.push_back(composite_pixel({sky, view}));
    n_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
  endtask

  function automatic logic [15:0] clamp16(longint v);
    if (v > 32767) return 16'h7FFF;
    if (v < -32768) return 16'h8000;
    return 16'(v);
  endfunction

  // View near the sun direction or its opposite, with a random offset
  function automatic logic [47:0] near_sun_view();
    longint sp, k;
    logic [15:0] c [3];
    longint s [3];
    s[0] = sh_dir_x; s[1] = sh_dir_y; s[2] = sh_dir_z;
    sp = longint'($urandom_range(0, 1 << $urandom_range(0, 12)));
    k  = ($urandom_range(3) == 0) ? -1 : 1;
    for (int i = 0; i < 3; i++)
      c[i] = clamp16(k * s[i] + longint'($urandom_range(0, 2 * sp)) - sp);
    return {c[2], c[1], c[0]};
  endfunction

  function automatic logic [95:0] rand_sky();
    if ($urandom_range(9) == 0) return {96{1'b1}};
    return {$urandom, $urandom, $urandom};
  endfunction

  function automatic logic [47:0] rand_view();
    case ($urandom_range(9))
      0:       return 48'd0;
      1, 2, 3: return 48'({$urandom, $urandom});
      default: return near_sun_view();
    endcase
  endfunction

  // Corner pixels under the reset register values, then register extremes
  task automatic test_directed;
    logic [95:0] full;
    full = {96{1'b1}};
    send_idle_pct = 0; recv_stall_pct = 0;
    send_pixel({16'd0, 16'd16384, 16'd0}, 96'd0);           // dead centre
    send_pixel({16'd0, 16'hC000, 16'd0}, 96'd5);            // opposite side
    send_pixel(48'd0, {$urandom, $urandom, $urandom});      // zero view
    send_pixel({16'd0, 16'h7FFF, 16'd0}, full);             // saturation
    send_pixel({16'd0, 16'h7FFF, 16'd60}, 96'd0);           // inside the disk, off centre
    send_pixel({16'h8000, 16'h8000, 16'h8000}, full);
    send_pixel({16'h7FFF, 16'h7FFF, 16'h7FFF}, 96'd0);
    send_pixel({16'd0, 16'd1, 16'd0}, 96'd0);
    drain();
    // largest colour and intensity, strongest darkening, widest radius
    write_all(16'h8000, 16'h8000, 16'h7FFF, {48{1'b1}}, 32'hFFFF_FFFF, 16'hFFFF, 24'hFF_FFFF);
    write_reg(CFG_UNUSED, 48'h1234);                        // ignored index
    send_pixel({16'h7FFF, 16'h8000, 16'h8000}, 96'd0);
    send_pixel({16'h7F00, 16'h8100, 16'h8000}, 96'd7);
    send_pixel({16'h8000, 16'h7FFF, 16'h7FFF}, full);
    send_pixel({16'h7000, 16'h8000, 16'h9000}, 96'd0);
    drain();
    // zero radius, then zero sun vector, then smallest radius and no darkening
    write_reg(CFG_ANGULAR_RADIUS, 48'd0);
    send_pixel({16'h7FFF, 16'h8000, 16'h8000}, 96'd9);
    drain();
    write_all(16'd0, 16'd0, 16'd0, 48'h1000_1000_1000, 32'h0001_0000, 16'd0, 24'd1);
    send_pixel({16'd0, 16'd100, 16'd0}, 96'd3);
    drain();
    write_reg(CFG_SUN_DIR_Z, 48'd1);
    send_pixel({16'd1000, 16'd0, 16'd0}, 96'd3);
    send_pixel({16'd0, 16'd0, 16'd0}, 96'd3);
    drain();
  endtask

  // Random settings and traffic under one idling mode
  task automatic test_random_phase(int items, int idle, int stall);
    logic [23:0] rad;
    case ($urandom_range(3))
      0:       rad = 24'hFF_FFFF;
      1:       rad = 24'(1 << $urandom_range(0, 23));
      default: rad = 24'($urandom);
    endcase
    write_all(16'($urandom), 16'($urandom), 16'($urandom), 48'({$urandom, $urandom}),
              $urandom, 16'($urandom), rad);
    send_idle_pct = idle; recv_stall_pct = stall;
    repeat (items) send_pixel(rand_view(), rand_sky());
    drain();
  endtask

  // Output held off long enough to fill the pipe and stall the input
  task automatic test_backpressure;
    write_all(16'd0, 16'd16384, 16'd0, 48'h1000_1000_1000, 32'h0001_0000,
              16'd39322, 24'hFF_FFFF);
    send_idle_pct = 0; recv_stall_pct = 0;
    hold_len = 400;
    repeat (300) send_pixel(rand_view(), rand_sky());
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0; s_axis_tdata = '0;
    cfg_we_i = 1'b0; cfg_idx_i = '0; cfg_data_i = '0;
    n_fail = 0; n_checked = 0; n_hits = 0; n_sent = 0; wdog = 0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_len = 0;
    sh_dir_x = SUN_DIR_X_RST; sh_dir_y = SUN_DIR_Y_RST; sh_dir_z = SUN_DIR_Z_RST;
    sh_color = SUN_COLOR_RST; sh_intens = SUN_INTENS_RST;
    sh_u = LIMB_U_RST; sh_radius = ANG_RADIUS_RST;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_backpressure();
    for (int p = 0; p < 3; p++) begin
      test_random_phase(120, 0, 0);
      test_random_phase(80, 88, 0);
      test_random_phase(80, 0, 88);
      test_random_phase(115, 6, 6);
    end

    $display("Checked %0d pixel results (%0d inside the disk) over %0d sent,",
             n_checked, n_hits, n_sent);
    $display("across directed corners, random registers, idling modes and a full-pipe stall.");
    if (n_fail == 0 && pixel_q.size() == 0) begin
      $display("sun_disk_limb_darkened_composite_top regression: pass");
    end else begin
      $display("sun_disk_limb_darkened_composite_top regression: fail");
    end
    $finish;
  end

endmodule
